// ----- sv/ftba_pkg.sv -----
// ----------------------------------------------------------------------------
// ftba_pkg
// Shared constants, register codes and item types of the feathered tile
// blend accumulator.
// ----------------------------------------------------------------------------
package ftba_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam int QUEUE_DEPTH = 16;
    localparam int OUT_DEPTH   = 16;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int OCNT_W      = $clog2(OUT_DEPTH + 1);

    localparam logic OP_ACCUM = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_TILE_SIZE    = 2'd2;
    localparam logic [1:0] REG_OVERLAP      = 2'd3;

    localparam logic [8:0]  RST_FRAME   = 9'd256;
    localparam logic [8:0]  RST_TILE    = 9'd64;
    localparam logic [7:0]  RST_OVERLAP = 8'd8;
    localparam logic [32:0] RST_RECIP   = 33'h0_2000_0000;

    localparam logic [16:0]        ONE_Q16    = 17'h1_0000;
    localparam logic signed [23:0] CSUM_MAX   = 24'sh7F_FFFF;
    localparam logic signed [23:0] CSUM_MIN   = -24'sh80_0000;
    localparam logic [18:0]        WSUM_MAX   = 19'h7_FFFF;
    localparam logic [7:0]         BYTE_MAX   = 8'd255;
    localparam logic [11:0]        NORM_SCALE = 12'd4080;

    typedef struct packed {
        logic               op;
        logic               act;
        logic signed [15:0] r;
        logic signed [15:0] g;
        logic signed [15:0] b;
    } fcarry_t;

    typedef struct packed {
        logic               op;
        logic               act;
        logic signed [15:0] cr;
        logic signed [15:0] cg;
        logic signed [15:0] cb;
        logic [16:0]        wt;
    } qitem_t;

    typedef struct packed {
        logic signed [23:0] sr;
        logic signed [23:0] sg;
        logic signed [23:0] sb;
        logic [18:0]        ws;
    } entry_t;

    typedef struct packed {
        logic   valid;
        logic   cov;
        entry_t e;
    } rd_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       covered;
    } result_t;

endpackage

// ----- sv/feathered_tile_blend_accumulator.sv -----
// ----------------------------------------------------------------------------
// feathered_tile_blend_accumulator
// Blends overlapping tiles into one frame with linear feather weights and
// reads out normalized, cleared pixels.
//
//   channel   handshake          payload
//   s_        s_valid/s_ready    opcode, tile origin, position, samples, pixel
//   m_        m_valid/m_ready    red/green/blue bytes, covered
//   cfg_      cfg_we             cfg_addr, cfg_wdata
//
// One request per cycle while s_ready is high; a readout result passes
// 7 weight stages, the queue, the store access and 9 normalization stages.
// After reset a clearing pass zeroes all MAX_WIDTH*MAX_HEIGHT store entries.
// A write of the overlap register starts the reciprocal unit; s_ready drops
// during both and when queue credits run out; readouts wait for result credits.
// ----------------------------------------------------------------------------
module feathered_tile_blend_accumulator #(
    parameter int MAX_WIDTH  = ftba_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ftba_pkg::DEF_MAX_HEIGHT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_addr,
    input  logic [8:0]         cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_opcode,
    input  logic [7:0]         s_tile_left,
    input  logic [7:0]         s_tile_top,
    input  logic [7:0]         s_col_in_tile,
    input  logic [7:0]         s_row_in_tile,
    input  logic signed [15:0] s_red_sample,
    input  logic signed [15:0] s_green_sample,
    input  logic signed [15:0] s_blue_sample,
    input  logic [7:0]         s_pixel_col,
    input  logic [7:0]         s_pixel_row,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_red_out,
    output logic [7:0]         m_green_out,
    output logic [7:0]         m_blue_out,
    output logic               m_covered
);
    import ftba_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int QW = AW + $bits(qitem_t);
    localparam int RW = $bits(result_t);

    logic              f_push;
    logic [AW-1:0]     f_idx;
    qitem_t            f_item;
    logic              q_valid, q_pop;
    logic [QW-1:0]     q_rdata;
    logic [QCNT_W-1:0] q_count;
    logic              clearing;
    rd_t               rd;
    logic              r_push;
    result_t           r_res;
    logic [RW-1:0]     o_rdata;
    logic [OCNT_W-1:0] o_count;
    result_t           m_res;

    ftba_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .aclk, .aresetn, .cfg_we, .cfg_addr, .cfg_wdata,
        .s_valid, .s_ready, .s_opcode, .s_tile_left, .s_tile_top,
        .s_col_in_tile, .s_row_in_tile, .s_red_sample, .s_green_sample,
        .s_blue_sample, .s_pixel_col, .s_pixel_row,
        .i_clearing(clearing), .i_q_count(q_count),
        .o_push(f_push), .o_idx(f_idx), .o_item(f_item)
    );

    ftba_fifo #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk, .aresetn,
        .i_push(f_push), .i_wdata({f_idx, f_item}),
        .i_pop(q_pop), .o_valid(q_valid), .o_rdata(q_rdata), .o_count(q_count)
    );

    ftba_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
        .aclk, .aresetn,
        .i_q_valid(q_valid), .i_q_idx(q_rdata[QW-1 -: AW]),
        .i_q_item(qitem_t'(q_rdata[$bits(qitem_t)-1:0])),
        .o_pop(q_pop), .i_out_count(o_count), .i_res_push(r_push),
        .o_clearing(clearing), .o_rd(rd)
    );

    ftba_norm u_norm (
        .aclk, .aresetn, .i_rd(rd), .o_push(r_push), .o_res(r_res)
    );

    ftba_fifo #(.WIDTH(RW), .DEPTH(OUT_DEPTH)) u_out (
        .aclk, .aresetn,
        .i_push(r_push), .i_wdata(r_res),
        .i_pop(m_valid && m_ready), .o_valid(m_valid), .o_rdata(o_rdata),
        .o_count(o_count)
    );

    assign m_res       = result_t'(o_rdata);
    assign m_red_out   = m_res.red;
    assign m_green_out = m_res.green;
    assign m_blue_out  = m_res.blue;
    assign m_covered   = m_res.covered;

endmodule

// ----- sv/ftba_fifo.sv -----
// ----------------------------------------------------------------------------
// ftba_fifo
// Small first-in first-out queue with show-ahead read and occupancy count.
// ----------------------------------------------------------------------------
module ftba_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_wdata,
    input  logic                       i_pop,
    output logic                       o_valid,
    output logic [WIDTH-1:0]           o_rdata,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PW-1:0]    wptr_reg;
    logic [PW-1:0]    rptr_reg;
    logic [CW-1:0]    count_reg;

    assign o_valid = (count_reg != '0);
    assign o_rdata = data_reg[rptr_reg];
    assign o_count = count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (i_push) begin
                wptr_reg <= (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (i_pop) begin
                rptr_reg <= (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (i_push && !i_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (!i_push && i_pop) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (i_push) begin
            data_reg[wptr_reg] <= i_wdata;
        end
    end

endmodule

// ----- sv/ftba_front.sv -----
// ----------------------------------------------------------------------------
// ftba_front
// Configuration registers, overlap reciprocal unit and the weight pipeline:
// clips the tile, forms the feather weights and weighted colours per sample.
// ----------------------------------------------------------------------------
module ftba_front #(
    parameter int MAX_WIDTH  = ftba_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ftba_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_we,
    input  logic [1:0]                              cfg_addr,
    input  logic [8:0]                              cfg_wdata,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic                                    s_opcode,
    input  logic [7:0]                              s_tile_left,
    input  logic [7:0]                              s_tile_top,
    input  logic [7:0]                              s_col_in_tile,
    input  logic [7:0]                              s_row_in_tile,
    input  logic signed [15:0]                      s_red_sample,
    input  logic signed [15:0]                      s_green_sample,
    input  logic signed [15:0]                      s_blue_sample,
    input  logic [7:0]                              s_pixel_col,
    input  logic [7:0]                              s_pixel_row,
    input  logic                                    i_clearing,
    input  logic [ftba_pkg::QCNT_W-1:0]             i_q_count,
    output logic                                    o_push,
    output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] o_idx,
    output ftba_pkg::qitem_t                        o_item
);
    import ftba_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);

    logic [8:0]  fw_reg, fh_reg, ts_reg;
    logic [7:0]  ov_reg;
    logic [32:0] recip_reg;
    logic [7:0]  rrem_reg;
    logic [5:0]  rcnt_reg;
    logic        rbusy_reg;
    logic [8:0]  rem_sh;

    logic [3:0]  cnt_reg;
    logic        accept;
    logic [5:0]  credit_sum;

    logic [6:0]  v_reg;
    logic        op0_reg;
    logic [7:0]  left0_reg, top0_reg, x0_reg, y0_reg, pc0_reg, pr0_reg;
    logic signed [15:0] r0_reg, g0_reg, b0_reg;

    fcarry_t     c_reg   [1:5];
    logic [AW-1:0] idx_reg [1:5];
    logic [8:0]  ax1_reg, ay1_reg, ax2_reg, ay2_reg, ax3_reg, ay3_reg;
    logic [40:0] pxx_reg, pxy_reg;
    logic [16:0] q0x_reg, q0y_reg;
    logic [24:0] qovx_reg, qovy_reg;
    logic [16:0] wx_reg, wy_reg, wt_reg;
    logic [AW-1:0] oidx_reg;
    qitem_t      oitem_reg;

    logic [8:0]  effw, effh, remw, remh, aw, ah, rowa, cola;
    logic        in_acc, in_rd;
    logic [8:0]  ax, ay;
    logic [AW-1:0] idx_acc, idx_rd;
    logic [16:0] q0x, q0y, wx, wy;
    logic [24:0] remx, remy;
    logic [33:0] wprod;
    logic signed [33:0] pr, pg, pb;

    function automatic logic [8:0] axis_num(input logic [7:0] org, input logic [7:0] pos,
                                            input logic [8:0] size, input logic [8:0] extent,
                                            input logic [7:0] ov);
        logic [9:0] far_edge;
        logic [9:0] reach;
        logic [8:0] diff;
        far_edge = {2'b00, org} + {1'b0, size};
        reach    = {2'b00, pos} + {2'b00, ov};
        diff     = size - {1'b0, pos};
        if (ov == 8'd0) begin
            return {1'b1, 8'd0};
        end else if (org != 8'd0 && pos < ov) begin
            return {1'b0, pos};
        end else if (far_edge < {1'b0, extent} && reach >= {1'b0, size}) begin
            return {1'b0, diff[7:0]};
        end else begin
            return {1'b1, 8'd0};
        end
    endfunction

    assign credit_sum = 6'(cnt_reg) + 6'(i_q_count);
    assign s_ready    = !rbusy_reg && !i_clearing && (credit_sum < 6'(QUEUE_DEPTH));
    assign accept     = s_valid && s_ready;
    assign rem_sh     = {rrem_reg, (rcnt_reg == 6'd0)};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg    <= RST_FRAME;
            fh_reg    <= RST_FRAME;
            ts_reg    <= RST_TILE;
            ov_reg    <= RST_OVERLAP;
            recip_reg <= RST_RECIP;
            rrem_reg  <= '0;
            rcnt_reg  <= '0;
            rbusy_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_FRAME_WIDTH:  fw_reg <= cfg_wdata;
                REG_FRAME_HEIGHT: fh_reg <= cfg_wdata;
                REG_TILE_SIZE:    ts_reg <= cfg_wdata;
                REG_OVERLAP: begin
                    ov_reg    <= cfg_wdata[7:0];
                    rbusy_reg <= 1'b1;
                    rcnt_reg  <= '0;
                    rrem_reg  <= '0;
                    recip_reg <= '0;
                end
            endcase
        end else if (rbusy_reg) begin
            if (rem_sh >= {1'b0, ov_reg}) begin
                rrem_reg  <= 8'(rem_sh - {1'b0, ov_reg});
                recip_reg <= {recip_reg[31:0], 1'b1};
            end else begin
                rrem_reg  <= rem_sh[7:0];
                recip_reg <= {recip_reg[31:0], 1'b0};
            end
            rcnt_reg <= rcnt_reg + 1'b1;
            if (rcnt_reg == 6'd32) begin
                rbusy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg   <= '0;
            cnt_reg <= '0;
        end else begin
            v_reg <= {v_reg[5:0], accept};
            if (accept && !v_reg[6]) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (!accept && v_reg[6]) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_comb begin
        effw = (32'(fw_reg) > MAX_WIDTH)  ? 9'(MAX_WIDTH)  : fw_reg;
        effh = (32'(fh_reg) > MAX_HEIGHT) ? 9'(MAX_HEIGHT) : fh_reg;
        remw = effw - {1'b0, left0_reg};
        remh = effh - {1'b0, top0_reg};
        aw   = (ts_reg < remw) ? ts_reg : remw;
        ah   = (ts_reg < remh) ? ts_reg : remh;
        in_acc = ({1'b0, left0_reg} < effw) && ({1'b0, top0_reg} < effh)
              && ({1'b0, x0_reg} < aw) && ({1'b0, y0_reg} < ah);
        in_rd  = ({1'b0, pc0_reg} < effw) && ({1'b0, pr0_reg} < effh);
        ax   = axis_num(left0_reg, x0_reg, aw, effw, ov_reg);
        ay   = axis_num(top0_reg, y0_reg, ah, effh, ov_reg);
        rowa = {1'b0, top0_reg} + {1'b0, y0_reg};
        cola = {1'b0, left0_reg} + {1'b0, x0_reg};
        idx_acc = AW'(rowa) * AW'(MAX_WIDTH) + AW'(cola);
        idx_rd  = AW'(pr0_reg) * AW'(MAX_WIDTH) + AW'(pc0_reg);

        q0x  = pxx_reg[32:16];
        q0y  = pxy_reg[32:16];
        remx = {1'b0, ax3_reg[7:0], 16'd0} - qovx_reg;
        remy = {1'b0, ay3_reg[7:0], 16'd0} - qovy_reg;
        wx   = ax3_reg[8] ? ONE_Q16 : ((remx >= 25'(ov_reg)) ? q0x_reg + 1'b1 : q0x_reg);
        wy   = ay3_reg[8] ? ONE_Q16 : ((remy >= 25'(ov_reg)) ? q0y_reg + 1'b1 : q0y_reg);
        wprod = {17'd0, wx_reg} * {17'd0, wy_reg};

        pr = 34'(c_reg[5].r) * 34'($signed({1'b0, wt_reg}));
        pg = 34'(c_reg[5].g) * 34'($signed({1'b0, wt_reg}));
        pb = 34'(c_reg[5].b) * 34'($signed({1'b0, wt_reg}));
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op0_reg   <= s_opcode;
            left0_reg <= s_tile_left;
            top0_reg  <= s_tile_top;
            x0_reg    <= s_col_in_tile;
            y0_reg    <= s_row_in_tile;
            r0_reg    <= s_red_sample;
            g0_reg    <= s_green_sample;
            b0_reg    <= s_blue_sample;
            pc0_reg   <= s_pixel_col;
            pr0_reg   <= s_pixel_row;
        end

        c_reg[1].op  <= op0_reg;
        c_reg[1].act <= (op0_reg == OP_READ) ? in_rd : in_acc;
        c_reg[1].r   <= r0_reg;
        c_reg[1].g   <= g0_reg;
        c_reg[1].b   <= b0_reg;
        idx_reg[1]   <= (op0_reg == OP_READ) ? idx_rd : idx_acc;
        ax1_reg      <= ax;
        ay1_reg      <= ay;
        for (int k = 2; k <= 5; k++) begin
            c_reg[k]   <= c_reg[k-1];
            idx_reg[k] <= idx_reg[k-1];
        end

        pxx_reg  <= {33'd0, ax1_reg[7:0]} * {8'd0, recip_reg};
        pxy_reg  <= {33'd0, ay1_reg[7:0]} * {8'd0, recip_reg};
        ax2_reg  <= ax1_reg;
        ay2_reg  <= ay1_reg;

        q0x_reg  <= q0x;
        q0y_reg  <= q0y;
        qovx_reg <= 25'(q0x) * 25'(ov_reg);
        qovy_reg <= 25'(q0y) * 25'(ov_reg);
        ax3_reg  <= ax2_reg;
        ay3_reg  <= ay2_reg;

        wx_reg   <= wx;
        wy_reg   <= wy;
        wt_reg   <= wprod[32:16];

        oidx_reg     <= idx_reg[5];
        oitem_reg.op  <= c_reg[5].op;
        oitem_reg.act <= c_reg[5].act;
        oitem_reg.cr  <= pr[31:16];
        oitem_reg.cg  <= pg[31:16];
        oitem_reg.cb  <= pb[31:16];
        oitem_reg.wt  <= wt_reg;
    end

    assign o_push = v_reg[6];
    assign o_idx  = oidx_reg;
    assign o_item = oitem_reg;

endmodule

// ----- sv/ftba_back.sv -----
// ----------------------------------------------------------------------------
// ftba_back
// Per-pixel store with read-modify-write, last-write forwarding, clearing
// pass after reset and readout capture.
// ----------------------------------------------------------------------------
module ftba_back #(
    parameter int MAX_WIDTH  = ftba_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ftba_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    i_q_valid,
    input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] i_q_idx,
    input  ftba_pkg::qitem_t                        i_q_item,
    output logic                                    o_pop,
    input  logic [ftba_pkg::OCNT_W-1:0]             i_out_count,
    input  logic                                    i_res_push,
    output logic                                    o_clearing,
    output ftba_pkg::rd_t                           o_rd
);
    import ftba_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    entry_t        mem [DEPTH];
    entry_t        rdata_reg;
    logic          clr_reg;
    logic [AW-1:0] clr_addr_reg;
    logic          b1_v_reg;
    qitem_t        b1_item_reg;
    logic [AW-1:0] b1_idx_reg;
    logic          lw_v_reg;
    logic [AW-1:0] lw_idx_reg;
    entry_t        lw_data_reg;
    logic [OCNT_W-1:0] rd_cnt_reg;
    rd_t           rd_reg;

    entry_t        old, sum;
    logic          we, item_we;
    logic [AW-1:0] waddr;
    entry_t        wdata;
    logic [OCNT_W:0] credit_sum;
    logic          pop_rd;

    function automatic logic signed [23:0] sat_add(input logic signed [23:0] a,
                                                   input logic signed [15:0] c);
        logic signed [24:0] s;
        s = 25'(a) + 25'(c);
        if (s > 25'(CSUM_MAX)) begin
            return CSUM_MAX;
        end else if (s < 25'(CSUM_MIN)) begin
            return CSUM_MIN;
        end else begin
            return s[23:0];
        end
    endfunction

    assign credit_sum = (OCNT_W+1)'(rd_cnt_reg) + (OCNT_W+1)'(i_out_count);
    assign o_pop  = i_q_valid && !clr_reg
                 && (i_q_item.op == OP_ACCUM || credit_sum < (OCNT_W+1)'(OUT_DEPTH));
    assign pop_rd = o_pop && (i_q_item.op == OP_READ);
    assign o_clearing = clr_reg;
    assign o_rd = rd_reg;

    always_comb begin
        logic [19:0] ws_sum;
        old = (lw_v_reg && lw_idx_reg == b1_idx_reg) ? lw_data_reg : rdata_reg;
        ws_sum = {1'b0, old.ws} + {3'd0, b1_item_reg.wt};
        sum.sr = sat_add(old.sr, b1_item_reg.cr);
        sum.sg = sat_add(old.sg, b1_item_reg.cg);
        sum.sb = sat_add(old.sb, b1_item_reg.cb);
        sum.ws = ws_sum[19] ? WSUM_MAX : ws_sum[18:0];
        item_we = b1_v_reg && b1_item_reg.act;
        we      = clr_reg || item_we;
        waddr   = clr_reg ? clr_addr_reg : b1_idx_reg;
        wdata   = (clr_reg || b1_item_reg.op == OP_READ) ? '0 : sum;
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (o_pop) begin
            rdata_reg <= mem[i_q_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
            b1_v_reg     <= 1'b0;
            lw_v_reg     <= 1'b0;
            rd_cnt_reg   <= '0;
            rd_reg.valid <= 1'b0;
        end else begin
            if (clr_reg) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(DEPTH - 1)) begin
                    clr_reg <= 1'b0;
                end
            end
            b1_v_reg <= o_pop;
            if (item_we) begin
                lw_v_reg <= 1'b1;
            end
            if (pop_rd && !i_res_push) begin
                rd_cnt_reg <= rd_cnt_reg + 1'b1;
            end else if (!pop_rd && i_res_push) begin
                rd_cnt_reg <= rd_cnt_reg - 1'b1;
            end
            rd_reg.valid <= b1_v_reg && (b1_item_reg.op == OP_READ);
            rd_reg.cov   <= b1_item_reg.act && (old.ws != '0);
            rd_reg.e     <= old;
        end
    end

    always_ff @(posedge aclk) begin
        if (o_pop) begin
            b1_item_reg <= i_q_item;
            b1_idx_reg  <= i_q_idx;
        end
        if (item_we) begin
            lw_idx_reg  <= b1_idx_reg;
            lw_data_reg <= wdata;
        end
    end

endmodule

// ----- sv/ftba_norm.sv -----
// ----------------------------------------------------------------------------
// ftba_norm
// Readout normalization: clamp tests, scale by 4080 and an eight-stage
// restoring divide by the weight sum per channel.
// ----------------------------------------------------------------------------
module ftba_norm (
    input  logic              aclk,
    input  logic              aresetn,
    input  ftba_pkg::rd_t     i_rd,
    output logic              o_push,
    output ftba_pkg::result_t o_res
);
    import ftba_pkg::*;

    logic [8:0]  v_reg;
    logic        cov_reg [0:8];
    logic [2:0]  z_reg   [0:8];
    logic [2:0]  f_reg   [0:8];
    logic [18:0] ws_reg  [0:8];
    logic [26:0] rem_reg [0:8][3];
    logic [7:0]  q_reg   [0:8][3];

    logic signed [23:0] s [3];
    logic [7:0]  byte_out [3];

    assign s[0] = i_rd.e.sr;
    assign s[1] = i_rd.e.sg;
    assign s[2] = i_rd.e.sb;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= {v_reg[7:0], i_rd.valid};
        end
    end

    always_ff @(posedge aclk) begin
        cov_reg[0] <= i_rd.cov;
        ws_reg[0]  <= i_rd.e.ws;
        for (int ch = 0; ch < 3; ch++) begin
            z_reg[0][ch]   <= s[ch][23] || (s[ch] == '0);
            f_reg[0][ch]   <= {s[ch][22:0], 4'd0} >= {8'd0, i_rd.e.ws};
            rem_reg[0][ch] <= 27'(s[ch][14:0]) * 27'(NORM_SCALE);
            q_reg[0][ch]   <= '0;
        end
        for (int k = 1; k <= 8; k++) begin
            cov_reg[k] <= cov_reg[k-1];
            ws_reg[k]  <= ws_reg[k-1];
            z_reg[k]   <= z_reg[k-1];
            f_reg[k]   <= f_reg[k-1];
            for (int ch = 0; ch < 3; ch++) begin
                if (rem_reg[k-1][ch] >= ({ws_reg[k-1], 8'd0} >> k)) begin
                    rem_reg[k][ch] <= rem_reg[k-1][ch] - ({ws_reg[k-1], 8'd0} >> k);
                    q_reg[k][ch]   <= {q_reg[k-1][ch][6:0], 1'b1};
                end else begin
                    rem_reg[k][ch] <= rem_reg[k-1][ch];
                    q_reg[k][ch]   <= {q_reg[k-1][ch][6:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            if (!cov_reg[8] || z_reg[8][ch]) begin
                byte_out[ch] = '0;
            end else if (f_reg[8][ch]) begin
                byte_out[ch] = BYTE_MAX;
            end else begin
                byte_out[ch] = q_reg[8][ch];
            end
        end
    end

    assign o_push        = v_reg[8];
    assign o_res.red     = byte_out[0];
    assign o_res.green   = byte_out[1];
    assign o_res.blue    = byte_out[2];
    assign o_res.covered = cov_reg[8];

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for feathered_tile_blend_accumulator: drives tile
// samples and readouts through several frame/tile/overlap settings, predicts
// each readout with a per-pixel blend store of its own and compares every
// result field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ftba_pkg::*;

    localparam int  STORE_SIZE  = 256 * 256;
    localparam int  DRAIN_WAIT  = 40;
    localparam longint LIMIT    = 3000000;

    typedef struct {
        logic               op;
        logic [7:0]         left;
        logic [7:0]         top;
        logic [7:0]         col;
        logic [7:0]         row;
        logic signed [15:0] smp [3];
        logic [7:0]         pcol;
        logic [7:0]         prow;
    } request_t;

    class blend_scoreboard;
        int      fw, fh, ts, ov;
        int      csum [3][STORE_SIZE];
        int      wsum [STORE_SIZE];
        result_t pending_q [$];
        int      errors;

        function new();
            fw = 256; fh = 256; ts = 64; ov = 8;
            errors = 0;
            foreach (wsum[i]) begin
                wsum[i] = 0;
                for (int c = 0; c < 3; c++) csum[c][i] = 0;
            end
        endfunction

        function void set_reg(logic [1:0] addr, logic [8:0] data);
            case (addr)
                REG_FRAME_WIDTH:  fw = data;
                REG_FRAME_HEIGHT: fh = data;
                REG_TILE_SIZE:    ts = data;
                REG_OVERLAP:      ov = data[7:0];
                default: ;
            endcase
        endfunction

        function longint axis_wt(int org, int pos, int size, int extent);
            if (ov == 0) return 65536;
            if (org > 0 && pos < ov) return (longint'(pos) * 65536) / ov;
            if (org + size < extent && pos + ov >= size)
                return (longint'(size - pos) * 65536) / ov;
            return 65536;
        endfunction

        function logic [7:0] norm_byte(int s, int ws);
            if (s <= 0) return 8'd0;
            if (longint'(s) * 16 >= ws) return BYTE_MAX;
            return 8'((longint'(s) * 4080) / ws);
        endfunction

        function void note_request(request_t r);
            int      w, h, aw, ah, idx;
            longint  wt, acc;
            result_t res;
            w = fw > 256 ? 256 : fw;
            h = fh > 256 ? 256 : fh;
            if (r.op == OP_ACCUM) begin
                if (r.left >= w || r.top >= h) return;
                aw = ts < w - r.left ? ts : w - r.left;
                ah = ts < h - r.top ? ts : h - r.top;
                if (r.col >= aw || r.row >= ah) return;
                wt = (axis_wt(r.left, r.col, aw, w) * axis_wt(r.top, r.row, ah, h)) / 65536;
                idx = (r.top + r.col * 0 + r.row) * 256 + r.left + r.col;
                for (int c = 0; c < 3; c++) begin
                    acc = csum[c][idx] + ((longint'(r.smp[c]) * wt) >>> 16);
                    if (acc > 8388607) acc = 8388607;
                    if (acc < -8388608) acc = -8388608;
                    csum[c][idx] = int'(acc);
                end
                acc = wsum[idx] + wt;
                wsum[idx] = acc > 524287 ? 524287 : int'(acc);
                return;
            end
            res = '0;
            if (r.pcol < w && r.prow < h) begin
                idx = r.prow * 256 + r.pcol;
                if (wsum[idx] > 0) begin
                    res.red     = norm_byte(csum[0][idx], wsum[idx]);
                    res.green   = norm_byte(csum[1][idx], wsum[idx]);
                    res.blue    = norm_byte(csum[2][idx], wsum[idx]);
                    res.covered = 1'b1;
                end
                for (int c = 0; c < 3; c++) csum[c][idx] = 0;
                wsum[idx] = 0;
            end
            pending_q.push_back(res);
        endfunction

        function void check_result(result_t got);
            result_t exp;
            if (pending_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result r=%0d g=%0d b=%0d cov=%0b", $realtime,
                         got.red, got.green, got.blue, got.covered);
                return;
            end
            exp = pending_q.pop_front();
            if (exp != got) begin
                errors++;
                $display("%0t: expected r=%0d g=%0d b=%0d cov=%0b, got r=%0d g=%0d b=%0d cov=%0b",
                         $realtime, exp.red, exp.green, exp.blue, exp.covered,
                         got.red, got.green, got.blue, got.covered);
            end
        endfunction
    endclass

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_addr = REG_FRAME_WIDTH;
    logic [8:0]         cfg_wdata = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_opcode = OP_ACCUM;
    logic [7:0]         s_tile_left = '0, s_tile_top = '0;
    logic [7:0]         s_col_in_tile = '0, s_row_in_tile = '0;
    logic signed [15:0] s_red_sample = '0, s_green_sample = '0, s_blue_sample = '0;
    logic [7:0]         s_pixel_col = '0, s_pixel_row = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [7:0]         m_red_out, m_green_out, m_blue_out;
    logic               m_covered;

    blend_scoreboard sb = new();
    longint          cycles = 0;
    int              stall_hold = 0;
    bit              sender_quiet = 0;

    feathered_tile_blend_accumulator i_dut (.*);

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("feathered_tile_blend_accumulator: mismatch");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result('{m_red_out, m_green_out, m_blue_out, m_covered});
        if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
        end else if ($urandom_range(0, 3) != 0) begin
            m_ready    <= 1'b1;
            stall_hold <= $urandom_range(0, 20);
        end else begin
            m_ready    <= 1'b0;
            stall_hold <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                       : $urandom_range(0, 3);
        end
    end

    task automatic send(request_t r);
        s_valid        <= 1'b1;
        s_opcode       <= r.op;
        s_tile_left    <= r.left;
        s_tile_top     <= r.top;
        s_col_in_tile  <= r.col;
        s_row_in_tile  <= r.row;
        s_red_sample   <= r.smp[0];
        s_green_sample <= r.smp[1];
        s_blue_sample  <= r.smp[2];
        s_pixel_col    <= r.pcol;
        s_pixel_row    <= r.prow;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(r);
        if (!sender_quiet) pause($urandom_range(0, 9) < 7 ? 0 :
                                 ($urandom_range(0, 9) == 0 ? $urandom_range(10, 40)
                                                            : $urandom_range(1, 3)));
    endtask

    task automatic pause(int n);
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending_q.size() != 0);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] addr, logic [8:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        sb.set_reg(addr, data);
        @(posedge aclk);
    endtask

    function automatic request_t accum(int l, int t, int c, int r, int sr, int sg, int sbl);
        request_t q;
        q = '{op: OP_ACCUM, left: l, top: t, col: c, row: r, smp: '{sr, sg, sbl},
              pcol: $urandom, prow: $urandom};
        return q;
    endfunction

    function automatic request_t readout(int c, int r);
        request_t q;
        q = '{op: OP_READ, left: $urandom, top: $urandom, col: $urandom, row: $urandom,
              smp: '{$urandom, $urandom, $urandom}, pcol: c, prow: r};
        return q;
    endfunction

    function automatic int coord(int lim);
        return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, lim);
    endfunction

    function automatic request_t random_request(int lim, int read_pct, bit hot);
        request_t q;
        q.op   = ($urandom_range(0, 99) < read_pct) ? OP_READ : OP_ACCUM;
        q.left = coord(lim);
        q.top  = coord(lim);
        q.col  = coord(lim);
        q.row  = coord(lim);
        q.pcol = coord(lim);
        q.prow = coord(lim);
        for (int c = 0; c < 3; c++) q.smp[c] = $urandom;
        if (hot && $urandom_range(0, 1)) begin
            q.smp[0] = 16'sh7FFF;
            q.smp[1] = -16'sh8000;
        end
        return q;
    endfunction

    initial begin
        static int phases [6][7] = '{
            '{20, 17, 8, 3, 150, 30, 24},
            '{1, 1, 1, 0, 250, 3, 2},
            '{511, 300, 256, 255, 100, 30, 255},
            '{0, 5, 4, 2, 30, 50, 6},
            '{9, 40, 5, 9'h104, 120, 30, 42},
            '{33, 7, 1, 0, 60, 40, 34}
        };
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        send(accum(0, 0, 0, 0, 4096, 4096, 4096));
        send(readout(0, 0));
        send(accum(64, 64, 3, 60, -32768, 32767, 2048));
        send(accum(60, 60, 7, 4, 1000, -1000, 32767));
        send(readout(67, 124));
        send(readout(67, 64));
        send(accum(255, 255, 0, 0, 4096, 4096, 4096));
        send(readout(255, 255));
        send(accum(200, 10, 255, 255, 4096, 4096, 4096));
        send(readout(100, 100));
        send(accum(0, 0, 63, 63, 2000, 3000, -4));
        send(accum(64, 0, 2, 63, 2000, 3000, 5000));
        send(readout(63, 63));
        send(readout(66, 63));
        for (int i = 0; i < 80; i++) send(random_request(80, 30, 0));
        drain();

        for (int p = 0; p < 6; p++) begin
            write_reg(REG_FRAME_WIDTH, phases[p][0]);
            write_reg(REG_FRAME_HEIGHT, phases[p][1]);
            write_reg(REG_TILE_SIZE, phases[p][2]);
            write_reg(REG_OVERLAP, phases[p][3]);
            cfg_we <= 1'b0;
            sender_quiet = (p % 3 == 1);
            if (p == 0) begin
                send(readout(20, 3));
                send(readout(3, 17));
                send(accum(8, 8, 2, 1, 4096, -4096, 100));
                send(readout(10, 9));
            end
            for (int i = 0; i < phases[p][4]; i++)
                send(random_request(phases[p][6], phases[p][5], p == 1));
            drain();
        end

        if (sb.errors == 0) begin
            $display("feathered_tile_blend_accumulator: match");
        end else begin
            $display("feathered_tile_blend_accumulator: mismatch");
        end
        $finish;
    end
endmodule
